// ===== hw/rtl/afl_pkg.sv =====
package afl_pkg;

   localparam int FIELD_BITS     = 16;
   localparam int MODE_BITS      = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [MODE_BITS-1:0] MODE_STRETCH   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_LETTERBOX = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CROP      = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPLAY_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPLAY_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ASPECT_MODE    = 2'd2;

   typedef struct packed {
      logic valid;
      logic zero;
      logic wider;
   } ctl_type;

endpackage

// ===== hw/rtl/afl_if.sv =====
interface afl_req_if;
   logic                            valid;
   logic                            ready;
   logic [afl_pkg::FIELD_BITS-1:0] source_width;
   logic [afl_pkg::FIELD_BITS-1:0] source_height;

   modport source (output valid, output source_width, output source_height, input ready);
   modport sink (input valid, input source_width, input source_height, output ready);
endinterface

interface afl_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [afl_pkg::FIELD_BITS-1:0] crop_x;
   logic [afl_pkg::FIELD_BITS-1:0] crop_y;
   logic [afl_pkg::FIELD_BITS-1:0] crop_width;
   logic [afl_pkg::FIELD_BITS-1:0] crop_height;
   logic [afl_pkg::FIELD_BITS-1:0] dest_x;
   logic [afl_pkg::FIELD_BITS-1:0] dest_y;
   logic [afl_pkg::FIELD_BITS-1:0] dest_width;
   logic [afl_pkg::FIELD_BITS-1:0] dest_height;

   modport source (output valid, output crop_x, output crop_y, output crop_width,
                   output crop_height, output dest_x, output dest_y, output dest_width,
                   output dest_height, input ready);
   modport sink (input valid, input crop_x, input crop_y, input crop_width,
                 input crop_height, input dest_x, input dest_y, input dest_width,
                 input dest_height, output ready);
endinterface

// ===== hw/rtl/aspect_fit_layout.sv =====
// channel   | direction | beat contents
// ----------+-----------+-----------------------------------------------------------
// req_bus   | in        | source_width, source_height
// rsp_bus   | out       | crop_x/y/width/height, dest_x/y/width/height
// csr_*     | in        | write enable, index (0 dw, 1 dh, 2 mode), write data
//
// one beat in and one beat out per cycle while rsp_bus.ready is high; each request passes
// through the input register, multiply, divide setup, one quotient bit per cell of the
// divider row, and the output register.
// every stage holds its beat under stall and takes a new one once the next is free.
// synchronous reset clears the valid bits and the display registers to zero.
module aspect_fit_layout #(
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   afl_req_if.sink                             req_bus,
   afl_rsp_if.source                           rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [afl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [afl_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import afl_pkg::*;

   localparam int N = COORD_BITS;

   logic [N-1:0]          dw_ff, dh_ff;
   logic [MODE_BITS-1:0]  mode_ff;

   ctl_type       ch_ctl   [N+1];
   logic          ch_ready [N+1];
   logic [N-1:0]  ch_rem   [N+1];
   logic [N-1:0]  ch_lo    [N+1];
   logic [N-1:0]  ch_div   [N+1];
   logic [N-1:0]  ch_sw    [N+1];
   logic [N-1:0]  ch_sh    [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dw_ff   <= '0;
         dh_ff   <= '0;
         mode_ff <= MODE_STRETCH;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DISPLAY_WIDTH:  dw_ff   <= csr_write_data[N-1:0];
            CSR_DISPLAY_HEIGHT: dh_ff   <= csr_write_data[N-1:0];
            CSR_ASPECT_MODE:    mode_ff <= csr_write_data[MODE_BITS-1:0];
            default: begin
               dw_ff <= dw_ff;
            end
         endcase
      end
   end

   afl_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .sw_in     (req_bus.source_width[N-1:0]),
      .sh_in     (req_bus.source_height[N-1:0]),
      .dw        (dw_ff),
      .dh        (dh_ff),
      .mode      (mode_ff),
      .out_ready (ch_ready[0]),
      .out_ctl   (ch_ctl[0]),
      .out_rem   (ch_rem[0]),
      .out_lo    (ch_lo[0]),
      .out_div   (ch_div[0]),
      .out_sw    (ch_sw[0]),
      .out_sh    (ch_sh[0])
   );

   // divider row, one quotient bit per cell
   for (genvar i = 0; i < N; i++) begin : g_cell
      afl_div_cell #(.COORD_BITS(COORD_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (ch_ctl[i]),
         .in_ready  (ch_ready[i]),
         .in_rem    (ch_rem[i]),
         .in_lo     (ch_lo[i]),
         .in_div    (ch_div[i]),
         .in_sw     (ch_sw[i]),
         .in_sh     (ch_sh[i]),
         .out_ready (ch_ready[i+1]),
         .out_ctl   (ch_ctl[i+1]),
         .out_rem   (ch_rem[i+1]),
         .out_lo    (ch_lo[i+1]),
         .out_div   (ch_div[i+1]),
         .out_sw    (ch_sw[i+1]),
         .out_sh    (ch_sh[i+1])
      );
   end

   afl_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (ch_ctl[N]),
      .in_ready (ch_ready[N]),
      .in_quot  (ch_lo[N]),
      .in_sw    (ch_sw[N]),
      .in_sh    (ch_sh[N]),
      .dw       (dw_ff),
      .dh       (dh_ff),
      .mode     (mode_ff),
      .rsp_bus  (rsp_bus)
   );

endmodule

// ===== hw/rtl/afl_front.sv =====
module afl_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [COORD_BITS-1:0]            sw_in,
   input  logic [COORD_BITS-1:0]            sh_in,
   input  logic [COORD_BITS-1:0]            dw,
   input  logic [COORD_BITS-1:0]            dh,
   input  logic [afl_pkg::MODE_BITS-1:0]    mode,
   input  logic                             out_ready,
   output afl_pkg::ctl_type                 out_ctl,
   output logic [COORD_BITS-1:0]            out_rem,
   output logic [COORD_BITS-1:0]            out_lo,
   output logic [COORD_BITS-1:0]            out_div,
   output logic [COORD_BITS-1:0]            out_sw,
   output logic [COORD_BITS-1:0]            out_sh
);
   import afl_pkg::*;

   localparam int N = COORD_BITS;

   logic            a_v_ff;
   logic [N-1:0]    a_sw_ff, a_sh_ff;
   logic            b_v_ff, b_zero_ff;
   logic [2*N-1:0]  b_pa_ff, b_pb_ff;
   logic [N-1:0]    b_sw_ff, b_sh_ff;
   ctl_type         c_ctl_ff, c_ctl_in;
   logic [N-1:0]    c_rem_ff, c_lo_ff, c_div_ff, c_sw_ff, c_sh_ff, c_div_in;
   logic [2*N-1:0]  c_dvd_in;
   logic            take_a, take_b, take_c, wider;

   assign take_c   = !c_ctl_ff.valid || out_ready;
   assign take_b   = !b_v_ff || take_c;
   assign take_a   = !a_v_ff || take_b;
   assign in_ready = take_a;

   // divisor and dividend for the one division the mode needs
   always_comb begin
      wider = b_pa_ff > b_pb_ff;
      case (mode)
         MODE_STRETCH: begin
            c_dvd_in = b_pa_ff;
            c_div_in = b_sh_ff;
         end
         MODE_LETTERBOX: begin
            c_dvd_in = wider ? b_pb_ff : b_pa_ff;
            c_div_in = wider ? b_sw_ff : b_sh_ff;
         end
         default: begin
            c_dvd_in = wider ? b_pb_ff : b_pa_ff;
            c_div_in = wider ? dh : dw;
         end
      endcase
      c_ctl_in.valid = b_v_ff;
      c_ctl_in.zero  = b_zero_ff;
      c_ctl_in.wider = wider;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff         <= 1'b0;
         b_v_ff         <= 1'b0;
         c_ctl_ff.valid <= 1'b0;
      end else begin
         if (take_a) a_v_ff <= in_valid;
         if (take_b) b_v_ff <= a_v_ff;
         if (take_c) c_ctl_ff.valid <= c_ctl_in.valid;
      end
      if (take_a) begin
         a_sw_ff <= sw_in;
         a_sh_ff <= sh_in;
      end
      if (take_b) begin
         b_pa_ff   <= (2*N)'(a_sw_ff) * (2*N)'(dh);
         b_pb_ff   <= (2*N)'(dw) * (2*N)'(a_sh_ff);
         b_sw_ff   <= a_sw_ff;
         b_sh_ff   <= a_sh_ff;
         b_zero_ff <= (a_sw_ff == '0) || (a_sh_ff == '0) || (dw == '0) || (dh == '0);
      end
      if (take_c) begin
         c_ctl_ff.zero  <= c_ctl_in.zero;
         c_ctl_ff.wider <= c_ctl_in.wider;
         c_rem_ff       <= c_dvd_in[2*N-1:N];
         c_lo_ff        <= c_dvd_in[N-1:0];
         c_div_ff       <= c_div_in;
         c_sw_ff        <= b_sw_ff;
         c_sh_ff        <= b_sh_ff;
      end
   end

   assign out_ctl = c_ctl_ff;
   assign out_rem = c_rem_ff;
   assign out_lo  = c_lo_ff;
   assign out_div = c_div_ff;
   assign out_sw  = c_sw_ff;
   assign out_sh  = c_sh_ff;

endmodule

// ===== hw/rtl/afl_div_cell.sv =====
module afl_div_cell #(
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  afl_pkg::ctl_type      in_ctl,
   output logic                  in_ready,
   input  logic [COORD_BITS-1:0] in_rem,
   input  logic [COORD_BITS-1:0] in_lo,
   input  logic [COORD_BITS-1:0] in_div,
   input  logic [COORD_BITS-1:0] in_sw,
   input  logic [COORD_BITS-1:0] in_sh,
   input  logic                  out_ready,
   output afl_pkg::ctl_type      out_ctl,
   output logic [COORD_BITS-1:0] out_rem,
   output logic [COORD_BITS-1:0] out_lo,
   output logic [COORD_BITS-1:0] out_div,
   output logic [COORD_BITS-1:0] out_sw,
   output logic [COORD_BITS-1:0] out_sh
);
   import afl_pkg::*;

   localparam int N = COORD_BITS;

   ctl_type       ctl_ff;
   logic [N-1:0]  rem_ff, lo_ff, div_ff, sw_ff, sh_ff;
   logic [N-1:0]  rem_in, lo_in;
   logic [N:0]    trial, diff;
   logic          take, q_bit;

   assign take     = !ctl_ff.valid || out_ready;
   assign in_ready = take;

   // one restoring step: bring down the next dividend bit, try the subtract
   always_comb begin
      trial  = {in_rem, in_lo[N-1]};
      diff   = trial - {1'b0, in_div};
      q_bit  = trial >= {1'b0, in_div};
      rem_in = q_bit ? diff[N-1:0] : trial[N-1:0];
      lo_in  = {in_lo[N-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (take) begin
         ctl_ff.valid <= in_ctl.valid;
      end
      if (take) begin
         ctl_ff.zero  <= in_ctl.zero;
         ctl_ff.wider <= in_ctl.wider;
         rem_ff       <= rem_in;
         lo_ff        <= lo_in;
         div_ff       <= in_div;
         sw_ff        <= in_sw;
         sh_ff        <= in_sh;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_rem = rem_ff;
   assign out_lo  = lo_ff;
   assign out_div = div_ff;
   assign out_sw  = sw_ff;
   assign out_sh  = sh_ff;

endmodule

// ===== hw/rtl/afl_back.sv =====
module afl_back #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  afl_pkg::ctl_type              in_ctl,
   output logic                          in_ready,
   input  logic [COORD_BITS-1:0]         in_quot,
   input  logic [COORD_BITS-1:0]         in_sw,
   input  logic [COORD_BITS-1:0]         in_sh,
   input  logic [COORD_BITS-1:0]         dw,
   input  logic [COORD_BITS-1:0]         dh,
   input  logic [afl_pkg::MODE_BITS-1:0] mode,
   afl_rsp_if.source                     rsp_bus
);
   import afl_pkg::*;

   localparam int N = COORD_BITS;

   logic          out_v_ff;
   logic [N-1:0]  cx_ff, cy_ff, cw_ff, ch_ff, dx_ff, dy_ff, dwo_ff, dho_ff;
   logic [N-1:0]  cx_in, cy_in, cw_in, ch_in, dx_in, dy_in, dwo_in, dho_in;
   logic [N-1:0]  q_floor, q_even, gap;
   logic          take;

   assign take     = !out_v_ff || rsp_bus.ready;
   assign in_ready = take;

   always_comb begin
      q_floor = (in_quot == '0) ? N'(1) : in_quot;
      q_even  = {in_quot[N-1:1], 1'b0};
      cx_in   = '0;
      cy_in   = '0;
      cw_in   = in_sw;
      ch_in   = in_sh;
      dx_in   = '0;
      dy_in   = '0;
      dwo_in  = dw;
      dho_in  = dh;
      gap     = '0;
      case (mode)
         MODE_STRETCH: begin
            gap = '0;
         end
         MODE_LETTERBOX: begin
            if (in_ctl.wider) begin
               gap    = dh - q_floor;
               dho_in = q_floor;
               dy_in  = {1'b0, gap[N-1:1]};
            end else begin
               gap    = dw - q_floor;
               dwo_in = q_floor;
               dx_in  = {1'b0, gap[N-1:1]};
            end
         end
         default: begin
            // crop offset is halved, then forced even
            if (in_ctl.wider) begin
               gap   = in_sw - q_even;
               cw_in = q_even;
               cx_in = {1'b0, gap[N-1:2], 1'b0};
            end else begin
               gap   = in_sh - q_even;
               ch_in = q_even;
               cy_in = {1'b0, gap[N-1:2], 1'b0};
            end
         end
      endcase
      if (in_ctl.zero) begin
         cx_in  = '0;
         cy_in  = '0;
         cw_in  = '0;
         ch_in  = '0;
         dx_in  = '0;
         dy_in  = '0;
         dwo_in = '0;
         dho_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (take) begin
         out_v_ff <= in_ctl.valid;
      end
      if (take) begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         cw_ff  <= cw_in;
         ch_ff  <= ch_in;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         dwo_ff <= dwo_in;
         dho_ff <= dho_in;
      end
   end

   assign rsp_bus.valid       = out_v_ff;
   assign rsp_bus.crop_x      = FIELD_BITS'(cx_ff);
   assign rsp_bus.crop_y      = FIELD_BITS'(cy_ff);
   assign rsp_bus.crop_width  = FIELD_BITS'(cw_ff);
   assign rsp_bus.crop_height = FIELD_BITS'(ch_ff);
   assign rsp_bus.dest_x      = FIELD_BITS'(dx_ff);
   assign rsp_bus.dest_y      = FIELD_BITS'(dy_ff);
   assign rsp_bus.dest_width  = FIELD_BITS'(dwo_ff);
   assign rsp_bus.dest_height = FIELD_BITS'(dho_ff);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import afl_pkg::*;

   typedef logic [FIELD_BITS-1:0] extent_type;

   typedef struct {
      extent_type crop_x;
      extent_type crop_y;
      extent_type crop_width;
      extent_type crop_height;
      extent_type dest_x;
      extent_type dest_y;
      extent_type dest_width;
      extent_type dest_height;
   } layout_type;

   localparam int BATCHES_PER_PHASE = 4;
   localparam int SIZES_PER_BATCH   = 48;
   localparam int SETTLE_CYCLES     = 30;
   localparam int HOLD_OFF_CYCLES   = 300;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   afl_req_if req_bus();
   afl_rsp_if rsp_bus();

   aspect_fit_layout #(.COORD_BITS(FIELD_BITS)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow copy of the display registers
   extent_type           display_w;
   extent_type           display_h;
   logic [MODE_BITS-1:0] fit_mode;

   layout_type pending_layouts[$];
   int         mismatch_count = 0;
   int         send_idle_pct  = 0;
   int         stall_pct      = 0;
   int         cycle_count    = 0;
   int         hold_off_end   = 0;

   always #6 clock = ~clock;

   function automatic layout_type fit_layout(extent_type sw, extent_type sh);
      layout_type  r;
      logic [31:0] src_by_dh;
      logic [31:0] disp_by_sh;
      logic [31:0] product;
      extent_type  q;
      extent_type  diff;
      logic        wider;
      r = '{default: '0};
      if (sw != 0 && sh != 0 && display_w != 0 && display_h != 0) begin
         src_by_dh  = 32'(sw) * 32'(display_h);
         disp_by_sh = 32'(display_w) * 32'(sh);
         wider      = src_by_dh > disp_by_sh;
         r.crop_width  = sw;
         r.crop_height = sh;
         r.dest_width  = display_w;
         r.dest_height = display_h;
         if (fit_mode == MODE_LETTERBOX) begin
            if (wider) begin
               q = extent_type'(disp_by_sh / 32'(sw));
               if (q == 0) q = 1;
               diff = display_h - q;
               r.dest_height = q;
               r.dest_y      = diff >> 1;
            end else begin
               q = extent_type'(src_by_dh / 32'(sh));
               if (q == 0) q = 1;
               diff = display_w - q;
               r.dest_width = q;
               r.dest_x     = diff >> 1;
            end
         end else if (fit_mode != MODE_STRETCH) begin
            // crop to fill, also taken by the unused mode code
            if (wider) begin
               product = 32'(sh) * 32'(display_w);
               q       = extent_type'(product / 32'(display_h));
               q[0]    = 1'b0;
               diff    = sw - q;
               r.crop_width = q;
               r.crop_x     = diff >> 1;
               r.crop_x[0]  = 1'b0;
            end else begin
               product = 32'(sw) * 32'(display_h);
               q       = extent_type'(product / 32'(display_w));
               q[0]    = 1'b0;
               diff    = sh - q;
               r.crop_height = q;
               r.crop_y      = diff >> 1;
               r.crop_y[0]   = 1'b0;
            end
         end
      end
      return r;
   endfunction

   function automatic extent_type random_extent();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return '0;
      if (pick == 1) return 1;
      if (pick == 2) return '1;
      if (pick < 7) return extent_type'($urandom_range(1, 32));
      return extent_type'($urandom_range(1, 65535));
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic compare_field(string name, extent_type got, extent_type want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_DISPLAY_WIDTH:  display_w = data;
         CSR_DISPLAY_HEIGHT: display_h = data;
         CSR_ASPECT_MODE:    fit_mode  = data[MODE_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic set_display(extent_type w, extent_type h, logic [CSR_DATA_BITS-1:0] mode);
      write_reg(CSR_DISPLAY_WIDTH, w);
      write_reg(CSR_DISPLAY_HEIGHT, h);
      write_reg(CSR_ASPECT_MODE, mode);
   endtask

   task automatic send_size(extent_type sw, extent_type sh);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.source_width  <= sw;
      req_bus.source_height <= sh;
      do @(posedge clock); while (!req_bus.ready);
      pending_layouts.push_back(fit_layout(sw, sh));
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_layouts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver side
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= (cycle_count >= hold_off_end) && ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      layout_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_layouts.size() == 0) begin
            report_mismatch("result beat with nothing outstanding");
         end else begin
            want = pending_layouts.pop_front();
            compare_field("crop_x", rsp_bus.crop_x, want.crop_x);
            compare_field("crop_y", rsp_bus.crop_y, want.crop_y);
            compare_field("crop_width", rsp_bus.crop_width, want.crop_width);
            compare_field("crop_height", rsp_bus.crop_height, want.crop_height);
            compare_field("dest_x", rsp_bus.dest_x, want.dest_x);
            compare_field("dest_y", rsp_bus.dest_y, want.dest_y);
            compare_field("dest_width", rsp_bus.dest_width, want.dest_width);
            compare_field("dest_height", rsp_bus.dest_height, want.dest_height);
         end
      end
   end

   task automatic test_zero_dims();
      // display still at its reset size of zero
      send_size(100, 50);
      drain();
      set_display(640, 480, CSR_DATA_BITS'(MODE_LETTERBOX));
      send_size(0, 100);
      send_size(100, 0);
      send_size(0, 0);
      drain();
      write_reg(CSR_DISPLAY_WIDTH, 0);
      send_size(100, 100);
      drain();
      write_reg(CSR_DISPLAY_WIDTH, 640);
      write_reg(CSR_DISPLAY_HEIGHT, 0);
      send_size(100, 100);
      drain();
   endtask

   task automatic test_stretch();
      set_display(16'hFFFF, 1, CSR_DATA_BITS'(MODE_STRETCH));
      send_size(16'hFFFF, 16'hFFFF);
      send_size(1, 1);
      drain();
   endtask

   task automatic test_letterbox();
      set_display(1920, 1080, CSR_DATA_BITS'(MODE_LETTERBOX));
      send_size(640, 480);
      send_size(3840, 1080);
      send_size(1920, 1080);
      // shrunk side would truncate to zero and is held at one
      send_size(16'hFFFF, 1);
      send_size(1, 16'hFFFF);
      drain();
   endtask

   task automatic test_crop();
      set_display(1920, 1080, CSR_DATA_BITS'(MODE_CROP));
      send_size(640, 480);
      send_size(3841, 1081);
      send_size(16'hFFFF, 16'hFFFF);
      send_size(1, 1);
      drain();
   endtask

   task automatic test_unused_mode();
      // upper data bits are dropped, leaving the unused mode code
      write_reg(CSR_ASPECT_MODE, 16'hFFFF);
      write_reg(CSR_ASPECT_MODE + 1'b1, 16'h1234);
      send_size(1001, 777);
      send_size(777, 1001);
      drain();
   endtask

   task automatic test_backpressure();
      set_display(1280, 720, CSR_DATA_BITS'(MODE_LETTERBOX));
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_off_end  = cycle_count + HOLD_OFF_CYCLES;
      repeat (60) send_size(random_extent(), random_extent());
      drain();
   endtask

   task automatic test_random();
      int idle_table[4][2];
      int pick;
      idle_table = '{'{0, 0}, '{63, 0}, '{0, 63}, '{23, 23}};
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_table[phase][0];
         stall_pct     = idle_table[phase][1];
         for (int b = 0; b < BATCHES_PER_PHASE; b++) begin
            set_display(random_extent(), random_extent(),
                        {14'($urandom_range(0, 16'h3FFF)), 2'($urandom_range(0, 3))});
            for (int n = 0; n < SIZES_PER_BATCH; n++) begin
               pick = $urandom_range(0, 9);
               // now and then hit the display aspect exactly or just off it
               if (pick == 0)
                  send_size(display_w, display_h);
               else if (pick == 1)
                  send_size(display_w + 1'b1, display_h);
               else
                  send_size(random_extent(), random_extent());
            end
            drain();
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = '0;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.source_width  = '0;
      req_bus.source_height = '0;
      display_w             = '0;
      display_h             = '0;
      fit_mode              = MODE_STRETCH;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_dims();
      test_stretch();
      test_letterbox();
      test_crop();
      test_unused_mode();
      test_backpressure();
      test_random();

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout waiting for result beats");
      $display("status: fail");
      $finish;
   end

endmodule
